// File: sv/idea_round_defines.svh
// assertion helpers for the round datapath
`ifndef IDEA_ROUND_DEFINES_SVH
`define IDEA_ROUND_DEFINES_SVH

// same-cycle implication
`define IR_ASSERT_SAME(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("idea_round: same-cycle check failed");

// next-cycle implication
`define IR_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("idea_round: next-cycle check failed");

`endif

// File: sv/idea_pkg.sv
`default_nettype none

package idea_pkg;

    localparam int unsigned WORD_W = 16;
    localparam int unsigned PROD_W = 2 * WORD_W;
    localparam int unsigned IN_DATA_W = 10 * WORD_W;
    localparam int unsigned OUT_DATA_W = 4 * WORD_W;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [PROD_W-1:0] t_prod;

    // reduce a 16x16 product modulo 65537, zero operand standing for 65536
    function automatic t_word mm_fix(input t_prod p, input t_word x, input t_word y);
        t_word lo;
        t_word hi;
        t_word r;
        lo = p[WORD_W-1:0];
        hi = p[PROD_W-1:WORD_W];
        if (x == '0) begin
            r = t_word'(1) - y;
        end else if (y == '0) begin
            r = t_word'(1) - x;
        end else begin
            r = lo - hi + t_word'(lo < hi);
        end
        return r;
    endfunction

    function automatic t_prod mul16(input t_word x, input t_word y);
        return t_prod'(x) * t_prod'(y);
    endfunction

endpackage

`default_nettype wire

// File: sv/idea_round.sv
// One IDEA round (or the final output transform when i_tuser is high) per
// request. A new request can be taken every clock while the output is not
// stalled; results are held in the output register. The pipeline depth
// comes from the three dependent modulo-65537 multiplications, each split
// into a multiply stage and a reduce stage. Each stage holds its item while
// stalled and bubbles are squeezed out, so back-pressure costs no throughput.
`default_nettype none

`include "idea_round_defines.svh"

module idea_round
    import idea_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_tvalid,
    output logic                  i_tready,
    // in_first, in_second, in_third, in_fourth, subkey_one .. subkey_six
    input  wire  [IN_DATA_W-1:0]  i_tdata,
    // final_half
    input  wire  [0:0]            i_tuser,
    output logic                  o_tvalid,
    input  wire                   o_tready,
    // out_first, out_second, out_third, out_fourth
    output logic [OUT_DATA_W-1:0] o_tdata
);

    t_word xa, xb, xc, xd, k1, k2, k3, k4, k5, k6;
    logic  half;

    assign xa = i_tdata[0*WORD_W +: WORD_W];
    assign xb = i_tdata[1*WORD_W +: WORD_W];
    assign xc = i_tdata[2*WORD_W +: WORD_W];
    assign xd = i_tdata[3*WORD_W +: WORD_W];
    assign k1 = i_tdata[4*WORD_W +: WORD_W];
    assign k2 = i_tdata[5*WORD_W +: WORD_W];
    assign k3 = i_tdata[6*WORD_W +: WORD_W];
    assign k4 = i_tdata[7*WORD_W +: WORD_W];
    assign k5 = i_tdata[8*WORD_W +: WORD_W];
    assign k6 = i_tdata[9*WORD_W +: WORD_W];
    assign half = i_tuser[0];

    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic e1, e2, e3, e4, e5, e6;

    // stage loads when empty or when its item moves on
    assign e6 = !r_v6 || o_tready;
    assign e5 = !r_v5 || e6;
    assign e4 = !r_v4 || e5;
    assign e3 = !r_v3 || e4;
    assign e2 = !r_v2 || e3;
    assign e1 = !r_v1 || e2;
    assign i_tready = e1;

    // stage 1: outer products, middle adds
    t_prod r_s1_pa, r_s1_pd;
    t_word r_s1_xa, r_s1_k1, r_s1_xd, r_s1_k4, r_s1_b, r_s1_c, r_s1_k5, r_s1_k6;
    logic  r_s1_half;
    // stage 2: reduce outer words
    t_word r_s2_a, r_s2_b, r_s2_c, r_s2_d, r_s2_k5, r_s2_k6;
    logic  r_s2_half;
    // stage 3: (a^c)*k5
    t_prod r_s3_pe;
    t_word r_s3_x, r_s3_k5, r_s3_a, r_s3_b, r_s3_c, r_s3_d, r_s3_k6;
    logic  r_s3_half;
    // stage 4: reduce e, sum with b^d
    t_word r_s4_e, r_s4_s, r_s4_a, r_s4_b, r_s4_c, r_s4_d, r_s4_k6;
    logic  r_s4_half;
    // stage 5: s*k6
    t_prod r_s5_pt;
    t_word r_s5_s, r_s5_k6, r_s5_e, r_s5_a, r_s5_b, r_s5_c, r_s5_d;
    logic  r_s5_half;
    // stage 6: output register
    t_word r_s6_o1, r_s6_o2, r_s6_o3, r_s6_o4;

    t_word n_t, n_u, n_o1, n_o2, n_o3, n_o4;

    always_comb begin
        n_t = mm_fix(r_s5_pt, r_s5_s, r_s5_k6);
        n_u = r_s5_e + n_t;
        if (r_s5_half) begin
            n_o1 = r_s5_a;
            n_o2 = r_s5_b;
            n_o3 = r_s5_c;
            n_o4 = r_s5_d;
        end else begin
            n_o1 = r_s5_a ^ n_t;
            n_o2 = r_s5_c ^ n_t;
            n_o3 = r_s5_b ^ n_u;
            n_o4 = r_s5_d ^ n_u;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (e1) r_v1 <= i_tvalid;
            if (e2) r_v2 <= r_v1;
            if (e3) r_v3 <= r_v2;
            if (e4) r_v4 <= r_v3;
            if (e5) r_v5 <= r_v4;
            if (e6) r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e1) begin
            r_s1_pa   <= mul16(xa, k1);
            r_s1_pd   <= mul16(xd, k4);
            r_s1_xa   <= xa;
            r_s1_k1   <= k1;
            r_s1_xd   <= xd;
            r_s1_k4   <= k4;
            // half round adds k2 to xc and k3 to xb, exchanging the middle words
            r_s1_b    <= half ? (xc + k2) : (xb + k2);
            r_s1_c    <= half ? (xb + k3) : (xc + k3);
            r_s1_k5   <= k5;
            r_s1_k6   <= k6;
            r_s1_half <= half;
        end
        if (e2) begin
            r_s2_a    <= mm_fix(r_s1_pa, r_s1_xa, r_s1_k1);
            r_s2_d    <= mm_fix(r_s1_pd, r_s1_xd, r_s1_k4);
            r_s2_b    <= r_s1_b;
            r_s2_c    <= r_s1_c;
            r_s2_k5   <= r_s1_k5;
            r_s2_k6   <= r_s1_k6;
            r_s2_half <= r_s1_half;
        end
        if (e3) begin
            r_s3_pe   <= mul16(r_s2_a ^ r_s2_c, r_s2_k5);
            r_s3_x    <= r_s2_a ^ r_s2_c;
            r_s3_k5   <= r_s2_k5;
            r_s3_a    <= r_s2_a;
            r_s3_b    <= r_s2_b;
            r_s3_c    <= r_s2_c;
            r_s3_d    <= r_s2_d;
            r_s3_k6   <= r_s2_k6;
            r_s3_half <= r_s2_half;
        end
        if (e4) begin
            r_s4_e    <= mm_fix(r_s3_pe, r_s3_x, r_s3_k5);
            r_s4_s    <= mm_fix(r_s3_pe, r_s3_x, r_s3_k5) + (r_s3_b ^ r_s3_d);
            r_s4_a    <= r_s3_a;
            r_s4_b    <= r_s3_b;
            r_s4_c    <= r_s3_c;
            r_s4_d    <= r_s3_d;
            r_s4_k6   <= r_s3_k6;
            r_s4_half <= r_s3_half;
        end
        if (e5) begin
            r_s5_pt   <= mul16(r_s4_s, r_s4_k6);
            r_s5_s    <= r_s4_s;
            r_s5_k6   <= r_s4_k6;
            r_s5_e    <= r_s4_e;
            r_s5_a    <= r_s4_a;
            r_s5_b    <= r_s4_b;
            r_s5_c    <= r_s4_c;
            r_s5_d    <= r_s4_d;
            r_s5_half <= r_s4_half;
        end
        if (e6) begin
            r_s6_o1 <= n_o1;
            r_s6_o2 <= n_o2;
            r_s6_o3 <= n_o3;
            r_s6_o4 <= n_o4;
        end
    end

    assign o_tvalid = r_v6;
    assign o_tdata  = {r_s6_o4, r_s6_o3, r_s6_o2, r_s6_o1};

    `IR_ASSERT_SAME(a_empty_out_takes, !r_v6, i_tready)
    `IR_ASSERT_NEXT(a_accept_lands, i_tvalid && i_tready, r_v1)
    `IR_ASSERT_NEXT(a_stall_holds, r_v3 && !e4, r_v3 && $stable(r_s3_pe))

endmodule

`default_nettype wire
